// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication within the same cycle, disabled during reset
`define RFDAF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// implication in the next cycle, disabled during reset
`define RFDAF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/rfdaf_pkg.sv -----
// shared types and constants of the receive frame filter
package rfdaf_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int ADDR_BITS     = 16;
    localparam int ACK_FRAME_LEN = 3;
    localparam int LEN_BITS      = 7;
    localparam int SEQ_BITS      = 8;
    localparam int VERDICT_BITS  = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = ADDR_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADDR_FILTER  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACK_IGNORE   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUP_FILTER   = 2'd3;

    typedef enum logic [VERDICT_BITS-1:0] {
        VERDICT_DELIVER    = 3'd0,
        VERDICT_ACK        = 3'd1,
        VERDICT_PARSE_FAIL = 3'd2,
        VERDICT_NOT_FOR_US = 3'd3,
        VERDICT_DUPLICATE  = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REPORT
    } t_state;

    // one history entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] sender;
        logic [SEQ_BITS-1:0]  seq;
    } t_entry;

    // lookup walking down the cell chain
    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] sender;
        logic [SEQ_BITS-1:0]  seq;
        logic                 hit;
    } t_query;

endpackage

// ----- sv/rfdaf_cell.sv -----
// one history cell: holds an entry, compares a passing lookup, shifts on push
module rfdaf_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rfdaf_pkg::t_entry i_entry,
    output rfdaf_pkg::t_entry o_entry,
    input  rfdaf_pkg::t_query i_query,
    output rfdaf_pkg::t_query o_query
);
    import rfdaf_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_query r_query;
    t_query n_query;

    // entry shift and lookup compare
    always_comb begin
        n_entry = i_push ? i_entry : r_entry;
        n_query = i_query;
        n_query.hit = i_query.hit | (i_query.valid &&
                      (i_query.sender == r_entry.sender) && (i_query.seq == r_entry.seq));
    end

    // history starts zeroed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_query <= '0;
        end else begin
            r_entry <= n_entry;
            r_query <= n_query;
        end
    end

    assign o_entry = r_entry;
    assign o_query = r_query;

endmodule

// ----- sv/rfdaf_ctrl.sv -----
// configuration registers, header prefilter and transaction sequencer
module rfdaf_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfdaf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rfdaf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [rfdaf_pkg::LEN_BITS-1:0]      i_frame_length,
    input  logic                                i_parse_ok,
    input  logic [rfdaf_pkg::ADDR_BITS-1:0]     i_dest_address,
    input  logic [rfdaf_pkg::ADDR_BITS-1:0]     i_src_address,
    input  logic [rfdaf_pkg::SEQ_BITS-1:0]      i_seq_number,
    output rfdaf_pkg::t_query                   o_query,
    input  rfdaf_pkg::t_query                   i_chain_end,
    output logic                                o_push,
    output rfdaf_pkg::t_entry                   o_push_entry,
    output logic                                o_done,
    output logic [rfdaf_pkg::VERDICT_BITS-1:0]  o_verdict
);
    import rfdaf_pkg::*;

    t_state                r_state;
    t_state                n_state;
    t_verdict              r_verdict;
    t_verdict              n_verdict;
    logic [ADDR_BITS-1:0]  r_node_address;
    logic                  r_addr_filter_on;
    logic                  r_ack_ignore_on;
    logic                  r_dup_filter_on;
    logic                  accept;
    t_verdict              pre_verdict;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address   <= '0;
            r_addr_filter_on <= 1'b1;
            r_ack_ignore_on  <= 1'b0;
            r_dup_filter_on  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_ADDRESS: r_node_address   <= i_cfg_data[ADDR_BITS-1:0];
                CFG_ADDR_FILTER:  r_addr_filter_on <= i_cfg_data[0];
                CFG_ACK_IGNORE:   r_ack_ignore_on  <= i_cfg_data[0];
                CFG_DUP_FILTER:   r_dup_filter_on  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // verdict from the header alone, in priority order
    always_comb begin
        if (r_ack_ignore_on && (i_frame_length == LEN_BITS'(ACK_FRAME_LEN))) begin
            pre_verdict = VERDICT_ACK;
        end else if (!i_parse_ok) begin
            pre_verdict = VERDICT_PARSE_FAIL;
        end else if (r_addr_filter_on && (i_dest_address != r_node_address) &&
                     (i_dest_address != '0)) begin
            pre_verdict = VERDICT_NOT_FOR_US;
        end else begin
            pre_verdict = VERDICT_DELIVER;
        end
    end

    assign accept = i_start && (r_state == ST_IDLE);

    // sequencer: launch lookup, wait for chain end, report
    always_comb begin
        n_state          = r_state;
        n_verdict        = r_verdict;
        o_query          = '0;
        o_push           = 1'b0;
        o_push_entry     = '{sender: i_chain_end.sender, seq: i_chain_end.seq};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_verdict = pre_verdict;
                    if ((pre_verdict == VERDICT_DELIVER) && r_dup_filter_on) begin
                        o_query.valid  = 1'b1;
                        o_query.sender = i_src_address;
                        o_query.seq    = i_seq_number;
                        n_state        = ST_SEARCH;
                    end else begin
                        n_state = ST_REPORT;
                    end
                end
            end
            ST_SEARCH: begin
                if (i_chain_end.valid) begin
                    if (i_chain_end.hit) begin
                        n_verdict = VERDICT_DUPLICATE;
                    end else begin
                        n_verdict = VERDICT_DELIVER;
                        o_push    = 1'b1;
                    end
                    n_state = ST_REPORT;
                end
            end
            ST_REPORT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_done    = (r_state == ST_REPORT);
    assign o_verdict = r_verdict;

endmodule

// ----- sv/rx_frame_dup_addr_filter_core.sv -----
// top level of the receive frame filter with duplicate history
// A frame header is taken when start is high and busy is low; its verdict
// appears on o_verdict with o_done high for exactly one cycle and must be
// taken then, as the receiver cannot stall. Frames decided by ack length,
// parse status or address (or any frame while duplicate filtering is off)
// report in the cycle after acceptance and free the block in the cycle after
// that. With duplicate filtering on, the lookup walks the chain of
// HISTORY_DEPTH history cells one cell per cycle, through the register of each
// cell in turn, and the block takes no new frame until the verdict has been
// reported; a delivered frame shifts into the front cell as its verdict is
// registered. Reset clears the history to zeros.
module rx_frame_dup_addr_filter_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfdaf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [rfdaf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic [rfdaf_pkg::LEN_BITS-1:0]      i_frame_length,
    input  logic                                i_parse_ok,
    input  logic [rfdaf_pkg::ADDR_BITS-1:0]     i_dest_address,
    input  logic [rfdaf_pkg::ADDR_BITS-1:0]     i_src_address,
    input  logic [rfdaf_pkg::SEQ_BITS-1:0]      i_seq_number,
    output logic                                o_done,
    output logic [rfdaf_pkg::VERDICT_BITS-1:0]  o_verdict
);
    import rfdaf_pkg::*;

    t_query query_link [HISTORY_DEPTH+1];
    t_entry entry_link [HISTORY_DEPTH+1];
    logic   push;

    // sequencer and configuration
    rfdaf_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .o_busy         (busy),
        .i_frame_length (i_frame_length),
        .i_parse_ok     (i_parse_ok),
        .i_dest_address (i_dest_address),
        .i_src_address  (i_src_address),
        .i_seq_number   (i_seq_number),
        .o_query        (query_link[0]),
        .i_chain_end    (query_link[HISTORY_DEPTH]),
        .o_push         (push),
        .o_push_entry   (entry_link[0]),
        .o_done         (o_done),
        .o_verdict      (o_verdict)
    );

    // history chain, front cell first
    for (genvar k = 0; k < HISTORY_DEPTH; k++) begin : g_cell
        rfdaf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_push  (push),
            .i_entry (entry_link[k]),
            .o_entry (entry_link[k+1]),
            .i_query (query_link[k]),
            .o_query (query_link[k+1])
        );
    end

endmodule

// ----- sv/rfdaf_checker.sv -----
// port-level checks of the receive frame filter and their binding
`include "assert_macros.svh"

module rfdaf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_done,
    input logic [rfdaf_pkg::VERDICT_BITS-1:0]  o_verdict
);
    import rfdaf_pkg::*;

    // an accepted transaction keeps the block busy in the next cycle
    `RFDAF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a verdict strobe lasts a single cycle
    `RFDAF_ASSERT_NEXT(a_done_pulse, o_done, !o_done)
    // verdicts only come while a transaction is open
    `RFDAF_ASSERT_SAME(a_done_busy, o_done, busy)
    // verdict code is one of the defined ones
    `RFDAF_ASSERT_SAME(a_verdict_code, o_done, o_verdict <= VERDICT_BITS'(VERDICT_DUPLICATE))

endmodule

bind rx_frame_dup_addr_filter_core rfdaf_checker u_rfdaf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_done    (o_done),
    .o_verdict (o_verdict)
);
